[rtl/core/dhss_pkg.sv]
// Shared types and constants of the double-hash DNA word set.
// Used by the controller, the datapath and the top level.
package dhss_pkg;

    localparam int KEY_W     = 28;
    localparam int LETTERS_W = 24;
    localparam int LEN_W     = 4;
    localparam int IDX_W     = 4;
    localparam int MOD_W     = 2;

    localparam logic [LEN_W-1:0] MAX_LETTERS = 4'd12;
    localparam logic [MOD_W-1:0] MOD_LAST    = 2'd2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_FIND   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_KEY,
        ST_MOD,
        ST_PINIT,
        ST_READ,
        ST_CHECK,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic key_step;
        logic mod_step;
        logic probe_init;
        logic rd_en;
        logic check;
        logic advance;
        logic wr_en;
        logic clr_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic len_zero;
        logic key_last;
        logic mod_last;
        logic hit;
        logic empty;
        logic last_probe;
        logic clear_last;
        logic is_insert;
    } t_dp_sts;

endpackage

[rtl/core/dhss_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module dhss_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 4093
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/dhss_ctrl.sv]
// Sequencer of the double-hash word set: clear sweep, key build, mod, probe walk.
// Depends on dhss_pkg; drives commands into dhss_dp.
module dhss_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    input  dhss_pkg::t_dp_sts i_sts,
    output dhss_pkg::t_dp_cmd o_cmd
);
    import dhss_pkg::*;

    t_state  r_state;
    t_state  n_state;
    logic    r_valid;
    logic    n_valid;
    t_dp_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    cmd.load = 1'b1;
                    n_state  = ST_KEY;
                end
            end
            ST_KEY: begin
                if (i_sts.len_zero) begin
                    n_state = ST_FINISH;
                end else begin
                    cmd.key_step = 1'b1;
                    if (i_sts.key_last) begin
                        n_state = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                cmd.mod_step = 1'b1;
                if (i_sts.mod_last) begin
                    n_state = ST_PINIT;
                end
            end
            ST_PINIT: begin
                cmd.probe_init = 1'b1;
                n_state        = ST_READ;
            end
            ST_READ: begin
                cmd.rd_en = 1'b1;
                n_state   = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.check = 1'b1;
                priority if (i_sts.hit) begin
                    n_state = ST_FINISH;
                end else if (i_sts.empty) begin
                    cmd.wr_en = i_sts.is_insert;
                    n_state   = ST_FINISH;
                end else if (i_sts.last_probe) begin
                    n_state = ST_FINISH;
                end else begin
                    cmd.advance = 1'b1;
                    n_state     = ST_READ;
                end
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (!r_valid || !i_stall) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
        if (cmd.out_load) begin
            n_valid = 1'b1;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_cmd   = cmd;

`ifndef SYNTHESIS
    a_check_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK) |-> ($past(r_state) == ST_READ))
        else $error("probe check without a preceding read");
    a_write_in_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wr_en |-> (r_state == ST_CHECK && i_sts.empty && !i_sts.hit))
        else $error("table write outside an empty-slot check");
    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> r_valid)
        else $error("result load did not raise valid");
`endif

endmodule

[rtl/core/dhss_dp.sv]
// Datapath of the double-hash word set: key, two remainders, probe address, table.
// Depends on dhss_pkg and dhss_ram.
module dhss_dp #(
    parameter int TABLE_SLOTS = 4093
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dhss_pkg::t_dp_cmd                i_cmd,
    output dhss_pkg::t_dp_sts                o_sts,
    input  logic                             i_command,
    input  logic [dhss_pkg::LETTERS_W-1:0]   i_letters,
    input  logic [dhss_pkg::LEN_W-1:0]       i_word_length,
    output logic                             o_present,
    output logic                             o_table_full
);
    import dhss_pkg::*;

    localparam int AW = $clog2(TABLE_SLOTS);
    localparam logic [AW:0]   N_EXT   = (AW+1)'(TABLE_SLOTS);
    localparam logic [AW-1:0] LAST    = AW'(TABLE_SLOTS - 1);
    localparam logic [KEY_W-1:0] N_KEY   = KEY_W'(TABLE_SLOTS);
    localparam logic [KEY_W-1:0] NM1_KEY = KEY_W'(TABLE_SLOTS - 1);
    localparam logic [KEY_W-1:0] RECIP_A =
        KEY_W'((longint'(1) << KEY_W) / longint'(TABLE_SLOTS));
    localparam logic [KEY_W-1:0] RECIP_B =
        KEY_W'((longint'(1) << KEY_W) / longint'(TABLE_SLOTS - 1));

    logic                 r_cmd;
    logic [LETTERS_W-1:0] r_letters;
    logic                 r_len_zero;
    logic [IDX_W-1:0]     r_idx;
    logic [KEY_W-1:0]     r_key;
    logic [MOD_W-1:0]     r_mod_cnt;
    logic [KEY_W-1:0]     r_quo_a;
    logic [KEY_W-1:0]     r_quo_b;
    logic [KEY_W-1:0]     r_qn_a;
    logic [KEY_W-1:0]     r_qn_b;
    logic [AW-1:0]        r_rem_a;
    logic [AW-1:0]        r_rem_b;
    logic [AW-1:0]        r_pos;
    logic [AW-1:0]        r_step;
    logic [AW-1:0]        r_cnt;
    logic [AW-1:0]        r_clr;
    logic                 r_present;
    logic                 r_full;
    logic                 r_o_present;
    logic                 r_o_full;

    logic [LEN_W-1:0]     len_sat;
    logic [2:0]           code;
    logic [KEY_W-1:0]     n_key;
    logic [2*KEY_W-1:0]   prod_a;
    logic [2*KEY_W-1:0]   prod_b;
    logic [KEY_W-1:0]     diff_a;
    logic [KEY_W-1:0]     diff_b;
    logic [KEY_W-1:0]     fix_a;
    logic [KEY_W-1:0]     fix_b;
    logic [AW:0]          pos_sum;
    logic [AW:0]          pos_sub;
    logic [AW-1:0]        n_pos;
    logic [KEY_W-1:0]     rd_data;
    logic                 hit;
    logic                 empty;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [KEY_W-1:0]     wr_data;

    assign len_sat = (i_word_length > MAX_LETTERS) ? MAX_LETTERS : i_word_length;

    // Horner step from the last letter down: key = key*5 + (letter+1)
    assign code  = {1'b0, r_letters[{r_idx, 1'b0} +: 2]} + 3'd1;
    assign n_key = {r_key[KEY_W-3:0], 2'b00} + r_key + KEY_W'(code);

    // Quotient estimate by reciprocal multiply is low by at most one, so the
    // remainder needs one compare and subtract. Three steps run the key through.
    assign prod_a = (2*KEY_W)'(r_key) * (2*KEY_W)'(RECIP_A);
    assign prod_b = (2*KEY_W)'(r_key) * (2*KEY_W)'(RECIP_B);
    assign diff_a = r_key - r_qn_a;
    assign diff_b = r_key - r_qn_b;
    assign fix_a  = diff_a - N_KEY;
    assign fix_b  = diff_b - NM1_KEY;

    assign pos_sum = {1'b0, r_pos} + {1'b0, r_step};
    assign pos_sub = pos_sum - N_EXT;
    assign n_pos   = (pos_sum >= N_EXT) ? pos_sub[AW-1:0] : pos_sum[AW-1:0];

    assign hit   = (rd_data == r_key);
    assign empty = (rd_data == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd      <= i_command;
            r_letters  <= i_letters;
            r_len_zero <= (i_word_length == '0);
            r_idx      <= len_sat - IDX_W'(1);
            r_key      <= '0;
            r_mod_cnt  <= MOD_LAST;
            r_rem_a    <= '0;
            r_rem_b    <= '0;
            r_present  <= 1'b0;
            r_full     <= 1'b0;
        end
        if (i_cmd.key_step) begin
            r_key <= n_key;
            r_idx <= r_idx - IDX_W'(1);
        end
        if (i_cmd.mod_step) begin
            r_quo_a   <= prod_a[2*KEY_W-1:KEY_W];
            r_quo_b   <= prod_b[2*KEY_W-1:KEY_W];
            r_qn_a    <= r_quo_a * N_KEY;
            r_qn_b    <= r_quo_b * NM1_KEY;
            r_rem_a   <= (diff_a >= N_KEY)   ? fix_a[AW-1:0] : diff_a[AW-1:0];
            r_rem_b   <= (diff_b >= NM1_KEY) ? fix_b[AW-1:0] : diff_b[AW-1:0];
            r_mod_cnt <= r_mod_cnt - MOD_W'(1);
        end
        if (i_cmd.probe_init) begin
            r_pos  <= r_rem_a;
            r_step <= r_rem_b + AW'(1);
            r_cnt  <= '0;
        end
        if (i_cmd.check) begin
            r_present <= hit;
            r_full    <= !hit && !empty && (r_cnt == LAST);
        end
        if (i_cmd.advance) begin
            r_pos <= n_pos;
            r_cnt <= r_cnt + AW'(1);
        end
        if (i_cmd.out_load) begin
            r_o_present <= r_present;
            r_o_full    <= r_full;
        end
    end

    assign wr_en   = i_cmd.clr_step || i_cmd.wr_en;
    assign wr_addr = i_cmd.clr_step ? r_clr : r_pos;
    assign wr_data = i_cmd.clr_step ? '0 : r_key;

    dhss_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (r_pos),
        .o_rd_data (rd_data)
    );

    assign o_sts.len_zero   = r_len_zero;
    assign o_sts.key_last   = (r_idx == '0);
    assign o_sts.mod_last   = (r_mod_cnt == '0);
    assign o_sts.hit        = hit;
    assign o_sts.empty      = empty;
    assign o_sts.last_probe = (r_cnt == LAST);
    assign o_sts.clear_last = (r_clr == LAST);
    assign o_sts.is_insert  = (r_cmd == CMD_INSERT);

    assign o_present    = r_o_present;
    assign o_table_full = r_o_full;

`ifndef SYNTHESIS
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> ({1'b0, r_pos} < N_EXT))
        else $error("probe address beyond the table");
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_present && r_full))
        else $error("present and table_full both set");
    a_step_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.advance |-> (r_step != '0))
        else $error("zero probe step");
`endif

endmodule

[rtl/core/double_hash_string_set.sv]
// Double-hash DNA word set. Each input word carries an insert or find command and a
// word of 1 to 12 letters; the word becomes a base-5 key, which is looked up in a
// table of TABLE_SLOTS keys with open addressing (first slot key mod N, step
// 1 + key mod (N-1)). One result word per input word. One word is in flight at a
// time and passes through these steps: taking the word, L letters of key build
// (one letter a cycle), the reciprocal-multiply remainder for both moduli, setting
// up the probe, P probes on the single-read table memory, each a read and then a
// check, and loading the result, which waits while the previous result is still
// stalled at the output. An empty word goes straight from the key build step to
// loading the result. After reset the table is swept to empty at one slot a cycle,
// during which no input word is taken.
// Depends on dhss_pkg, dhss_ctrl, dhss_dp and dhss_ram.
module double_hash_string_set #(
    parameter int TABLE_SLOTS = 4093
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_command,
    input  logic [dhss_pkg::LETTERS_W-1:0] i_letters,
    input  logic [dhss_pkg::LEN_W-1:0]     i_word_length,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_present,
    output logic                           o_table_full
);
    import dhss_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    dhss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    dhss_dp #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_command     (i_command),
        .i_letters     (i_letters),
        .i_word_length (i_word_length),
        .o_present     (o_present),
        .o_table_full  (o_table_full)
    );

endmodule

[tb/sv/double_hash_string_set_test.sv]
// Self-checking test of the double-hash DNA word set: directed words, then random
// traffic under several idle and stall mixes.
// Depends on dhss_pkg and the double_hash_string_set top level.
module double_hash_string_set_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dhss_pkg::*;

    localparam int SLOTS    = 4093;
    localparam int PHASE_N  = 150;
    localparam int SHOW_MAX = 10;

    typedef struct packed {
        logic present;
        logic full;
    } t_answer;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_valid       = 1'b0;
    logic                 i_command     = CMD_INSERT;
    logic [LETTERS_W-1:0] i_letters     = '0;
    logic [LEN_W-1:0]     i_word_length = '0;
    logic                 i_stall       = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic                 o_present;
    logic                 o_table_full;

    // Shadow copy of the key table and the answers still owed by the block.
    logic [KEY_W-1:0]     slot_table [SLOTS];
    int                   slots_used;
    t_answer              pending_answers [$];
    logic [LETTERS_W-1:0] known_letters [$];
    logic [LEN_W-1:0]     known_len [$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int words_sent    = 0;
    int results_seen  = 0;
    int hits_seen     = 0;
    int full_seen     = 0;
    int mismatches    = 0;
    t_answer want_ans;
    t_answer got_ans;

    double_hash_string_set #(.TABLE_SLOTS(SLOTS)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_letters    (i_letters),
        .i_word_length(i_word_length),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_present    (o_present),
        .o_table_full (o_table_full)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [KEY_W-1:0] dna_key(logic [LETTERS_W-1:0] letters,
                                                 logic [LEN_W-1:0] len);
        int unsigned n;
        int unsigned sum;
        int unsigned weight;
        int unsigned code;
        n = 32'((len > MAX_LETTERS) ? MAX_LETTERS : len);
        sum = 0;
        weight = 1;
        for (int i = 0; i < n; i++) begin
            code = 32'(letters[2*i +: 2]);
            sum += weight * (code + 1);
            weight *= 5;
        end
        return sum[KEY_W-1:0];
    endfunction

    // Walk the probe sequence on the shadow table; insert claims the empty slot.
    function automatic t_answer dna_lookup(logic cmd, logic [LETTERS_W-1:0] letters,
                                           logic [LEN_W-1:0] len);
        t_answer ans;
        logic [KEY_W-1:0] key;
        int unsigned pos;
        int unsigned step;
        ans = '{present: 1'b0, full: 1'b0};
        if (len == 0) return ans;
        key = dna_key(letters, len);
        pos = key % SLOTS;
        step = (1 + key % (SLOTS - 1)) % SLOTS;
        ans.full = 1'b1;
        for (int n = 0; n < SLOTS; n++) begin
            if (slot_table[pos] == key) begin
                ans.present = 1'b1;
                ans.full = 1'b0;
                break;
            end
            if (slot_table[pos] == 0) begin
                if (cmd == CMD_INSERT) begin
                    slot_table[pos] = key;
                    slots_used++;
                end
                ans.full = 1'b0;
                break;
            end
            pos += step;
            if (pos >= SLOTS) pos -= SLOTS;
        end
        return ans;
    endfunction

    task automatic send_word(logic cmd, logic [LETTERS_W-1:0] letters,
                             logic [LEN_W-1:0] len);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_letters     <= letters;
        i_word_length <= len;
        do @(posedge i_clk); while (o_stall);
        pending_answers.push_back(dna_lookup(cmd, letters, len));
        if (cmd == CMD_INSERT && len != 0) begin
            known_letters.push_back(letters);
            known_len.push_back(len);
        end
        words_sent++;
    endtask

    task automatic report_mismatch(string what, t_answer want, t_answer got);
        mismatches++;
        if (mismatches <= SHOW_MAX)
            $display("%0t: %s: expected present=%0b full=%0b, got present=%0b full=%0b",
                     $realtime, what, want.present, want.full, got.present, got.full);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got_ans = '{present: o_present, full: o_table_full};
            results_seen++;
            if (o_present) hits_seen++;
            if (o_table_full) full_seen++;
            if (pending_answers.size() == 0) begin
                report_mismatch("result with no word outstanding", '0, got_ans);
            end else begin
                want_ans = pending_answers.pop_front();
                if (got_ans !== want_ans)
                    report_mismatch("wrong result", want_ans, got_ans);
            end
        end
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Random word from the pool with junk above its length.
    task automatic send_known(logic cmd);
        int idx;
        logic [31:0] keep;
        logic [LETTERS_W-1:0] junk;
        logic [LEN_W-1:0] len;
        idx = $urandom_range(known_letters.size() - 1);
        len = known_len[idx];
        keep = (32'h1 << (2 * ((len > MAX_LETTERS) ? MAX_LETTERS : len))) - 1;
        junk = LETTERS_W'($urandom);
        if (len == MAX_LETTERS && $urandom_range(1)) len = LEN_W'($urandom_range(15, 12));
        send_word(cmd, (known_letters[idx] & keep[LETTERS_W-1:0]) |
                       (junk & ~keep[LETTERS_W-1:0]), len);
    endtask

    task automatic test_directed();
        logic [LETTERS_W-1:0] base;
        logic [LETTERS_W-1:0] other;
        send_idle_pct = 0;
        stall_pct = 0;
        // single letters A, C, G, T: find before insert, insert, insert again
        for (int l = 0; l < 4; l++) send_word(CMD_FIND, LETTERS_W'(l), 4'd1);
        for (int l = 0; l < 4; l++) send_word(CMD_INSERT, LETTERS_W'(l), 4'd1);
        send_word(CMD_INSERT, 24'h000003, 4'd1);
        send_word(CMD_FIND, 24'hFFFFFC, 4'd1);
        // longest words, all A and all T
        send_word(CMD_INSERT, 24'h000000, MAX_LETTERS);
        send_word(CMD_INSERT, 24'hFFFFFF, MAX_LETTERS);
        send_word(CMD_FIND, 24'hFFFFFF, MAX_LETTERS);
        // overlong lengths saturate to twelve letters
        send_word(CMD_FIND, 24'hFFFFFF, 4'd15);
        send_word(CMD_INSERT, 24'h000000, 4'd13);
        // empty word, both commands
        send_word(CMD_INSERT, 24'hABCDEF, 4'd0);
        send_word(CMD_FIND, 24'h123456, 4'd0);
        // bits above the length are ignored
        send_word(CMD_INSERT, 24'h00001B, 4'd3);
        send_word(CMD_FIND, 24'hFFFFDB, 4'd3);
        // two words sharing a home slot: the second one must step on
        base = LETTERS_W'($urandom);
        do other = LETTERS_W'($urandom);
        while (dna_key(other, MAX_LETTERS) % SLOTS != dna_key(base, MAX_LETTERS) % SLOTS ||
               dna_key(other, MAX_LETTERS) == dna_key(base, MAX_LETTERS));
        send_word(CMD_INSERT, base, MAX_LETTERS);
        send_word(CMD_FIND, other, MAX_LETTERS);
        send_word(CMD_INSERT, other, MAX_LETTERS);
        send_word(CMD_FIND, other, MAX_LETTERS);
        send_word(CMD_FIND, base, MAX_LETTERS);
    endtask

    task automatic send_random_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            send_word(CMD_INSERT, LETTERS_W'($urandom), LEN_W'($urandom_range(12, 1)));
        else if (pick < 70)
            send_known(CMD_FIND);
        else if (pick < 85)
            send_known(CMD_INSERT);
        else if (pick < 95)
            send_word(CMD_FIND, LETTERS_W'($urandom), LEN_W'($urandom_range(12, 1)));
        else
            send_word(1'($urandom_range(1)), LETTERS_W'($urandom),
                      $urandom_range(1) ? 4'd0 : LEN_W'($urandom_range(15, 13)));
    endtask

    task automatic test_random_mix();
        int send_mix [4];
        int stall_mix [4];
        send_mix  = '{0, 83, 0, 27};
        stall_mix = '{0, 0, 83, 27};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = send_mix[p];
            stall_pct = stall_mix[p];
            repeat (PHASE_N) send_random_word();
        end
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    initial begin
        for (int s = 0; s < SLOTS; s++) slot_table[s] = '0;
        slots_used = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_mix();

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (pending_answers.size() != 0) mismatches++;

        $display("Sent %0d words, checked %0d results: %0d found present, %0d on a full table.",
                 words_sent, results_seen, hits_seen, full_seen);
        $display("Table ended with %0d of %0d slots in use; %0d mismatches.",
                 slots_used, SLOTS, mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule
